// ----- hdl/bb3_pkg.sv -----
// shared types, constants and tables for the edge-aware 3x3 box blur
package bb3_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // register field widths
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // position counter widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int ROW_W  = OROW_W + 1;

  // pixel and window
  localparam int CH_W  = 8;
  localparam int N_CH  = 3;
  localparam int PIX_W = CH_W * N_CH;
  localparam int WIN_N = 9;

  // averaging arithmetic: floor(num / (2*count)) = (num * recip) >> RECIP_SHIFT
  localparam int CNT_W       = 4;
  localparam int SUM_W       = 12;
  localparam int NUM_W       = SUM_W + 1;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_pixel;
  } pix_out_t;

  // stage enables from the sequencer to the channel lanes
  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SH,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  // ceil(2^RECIP_SHIFT / (2*count)) for the neighbour counts that can occur
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    unique case (count)
      4'd2:    m = RECIP_W'(65536);
      4'd3:    m = RECIP_W'(43691);
      4'd4:    m = RECIP_W'(32768);
      4'd6:    m = RECIP_W'(21846);
      4'd9:    m = RECIP_W'(14564);
      default: m = RECIP_W'(131072);
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/bb3_linebuf.sv -----
// two row line buffers with a registered read port
module bb3_linebuf (
  input  logic                                clk,
  input  logic [bb3_pkg::COL_W-1:0]           rd_addr,
  output logic [bb3_pkg::PIX_W-1:0]           rd_upper_r,
  output logic [bb3_pkg::PIX_W-1:0]           rd_lower_r,
  input  logic                                we,
  input  logic [bb3_pkg::COL_W-1:0]           wr_addr,
  input  logic [bb3_pkg::PIX_W-1:0]           wr_upper,
  input  logic [bb3_pkg::PIX_W-1:0]           wr_lower
);
  import bb3_pkg::*;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      upper_mem[wr_addr] <= wr_upper;
      lower_mem[wr_addr] <= wr_lower;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_upper_r <= upper_mem[rd_addr];
    rd_lower_r <= lower_mem[rd_addr];
  end

endmodule

// ----- hdl/bb3_lane.sv -----
// one colour channel: masked window sum, then rounded average by reciprocal multiply
module bb3_lane (
  input  logic                                           clk,
  input  bb3_pkg::lane_ctl_t                             ctl,
  input  logic [bb3_pkg::WIN_N-1:0][bb3_pkg::CH_W-1:0]   px,
  input  logic [bb3_pkg::WIN_N-1:0]                      mask,
  input  logic [bb3_pkg::CNT_W-1:0]                      count,
  input  logic [bb3_pkg::RECIP_W-1:0]                    recip,
  output logic [bb3_pkg::CH_W-1:0]                       avg
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [NUM_W-1:0]  num_r;
  logic [PROD_W-1:0] prod_r;

  // sum of the in-frame neighbours
  always_comb begin
    sum = '0;
    for (int k = 0; k < WIN_N; k++) begin
      if (mask[k]) begin
        sum = sum + SUM_W'(px[k]);
      end
    end
  end

  // numerator 2*sum + count, then scaled by the reciprocal of 2*count
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      num_r <= {sum, 1'b0} + NUM_W'(count);
    end
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(num_r) * PROD_W'(recip);
    end
  end

  assign avg = prod_r[RECIP_SHIFT +: CH_W];

endmodule

// ----- hdl/box_blur_3x3_edge_aware.sv -----
// top level of the edge-aware 3x3 box blur: sequencer, window, counters and output merge
//
//  port group | direction | handshake         | payload
//  in_        | input     | in_valid/in_ready | pix_in_t (req_type, red/green/blue_in)
//  out_       | output    | out_valid/out_ready | pix_out_t (red/green/blue_out, last_pixel)
//  cfg_       | input     | cfg_we            | cfg_index, cfg_wdata
//
// a pixel is shifted in and, when it releases an output, passes on through the sum stage,
// multiply stage and output load; a drain shifts k times, k at most image_width+1.
// each shift needs a registered line buffer read ahead of it, which sets the shift pace.
// reset is synchronous, active low; the line buffers are not cleared.
// a stalled output holds the sequencer in its output state; inputs wait until idle.
module box_blur_3x3_edge_aware (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bb3_pkg::pix_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bb3_pkg::pix_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bb3_pkg::*;

  state_t state_r, state_nxt;

  logic [WIDTH_REG_W-1:0]  w_cfg_r;
  logic [HEIGHT_REG_W-1:0] h_cfg_r;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r;
  logic [OROW_W-1:0] out_row_r;
  logic [COL_W-1:0]  out_col_r;

  logic [WIN_N-1:0][PIX_W-1:0] win_r;
  logic [PIX_W-1:0]            pix_r;
  logic                        drain_r;

  logic [PIX_W-1:0] lb_upper;
  logic [PIX_W-1:0] lb_lower;

  logic take_pixel, pos_zero, frame_full, emit_now, in_col_wrap, out_col_wrap;
  logic do_shift, out_load, restart;
  lane_ctl_t lane_ctl;

  logic             col_lo, col_hi, row_lo, row_hi;
  logic [WIN_N-1:0] mask;
  logic [CNT_W-1:0] count;
  logic [RECIP_W-1:0] recip_r;
  logic             last_r;
  logic [N_CH-1:0][CH_W-1:0] avg;

  logic     out_valid_r;
  pix_out_t out_data_r;

  // effective frame size, out-of-range values clamped
  always_comb begin
    if (w_cfg_r == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (w_cfg_r > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg_r;
    end
    if (h_cfg_r == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (h_cfg_r > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg_r;
    end
  end

  // input position decode
  assign frame_full  = ({1'b0, in_row_r} >= {1'b0, h_eff});
  assign pos_zero    = (in_row_r == '0) && (in_col_r == '0);
  assign take_pixel  = (in_data.req_type == REQ_PIXEL) && !frame_full;
  assign emit_now    = (in_row_r >= ROW_W'(2)) ||
                       ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign in_col_wrap = ({1'b0, in_col_r} + WIDTH_REG_W'(1)) >= w_eff;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (take_pixel || !pos_zero)) begin
          state_nxt = ST_SH;
        end
      end
      ST_RD:  state_nxt = ST_SH;
      ST_SH: begin
        if (emit_now) begin
          state_nxt = ST_SUM;
        end else if (drain_r) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    do_shift        = (state_r == ST_SH);
    lane_ctl.sum_en = (state_r == ST_SUM);
    lane_ctl.mul_en = (state_r == ST_MUL);
    out_load        = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  end

  assign restart = cfg_we || (out_load && last_r);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_cfg_r <= WIDTH_RESET;
      h_cfg_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  w_cfg_r <= cfg_wdata[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: h_cfg_r <= cfg_wdata[HEIGHT_REG_W-1:0];
      endcase
    end
  end

  // captured transaction: pixel value, or black for a drain or for a pixel past a full frame
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r   <= take_pixel ? {in_data.red_in, in_data.green_in, in_data.blue_in} : '0;
      drain_r <= !take_pixel;
    end
  end

  // input position
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_row_r <= '0;
      in_col_r <= '0;
    end else if (do_shift) begin
      if (in_col_wrap) begin
        in_col_r <= '0;
        in_row_r <= in_row_r + ROW_W'(1);
      end else begin
        in_col_r <= in_col_r + COL_W'(1);
      end
    end
  end

  // 3x3 window, newest column on the right
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_r <= '0;
    end else if (do_shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r]     <= win_r[3 + r];
        win_r[3 + r] <= win_r[6 + r];
      end
      win_r[6] <= lb_upper;
      win_r[7] <= lb_lower;
      win_r[8] <= pix_r;
    end
  end

  // line buffers, read ahead at the current input column
  bb3_linebuf u_linebuf (
    .clk        (clk),
    .rd_addr    (in_col_r),
    .rd_upper_r (lb_upper),
    .rd_lower_r (lb_lower),
    .we         (do_shift),
    .wr_addr    (in_col_r),
    .wr_upper   (lb_lower),
    .wr_lower   (pix_r)
  );

  // neighbourhood mask of the output position
  always_comb begin
    col_lo = (out_col_r != '0);
    col_hi = ({1'b0, out_col_r} + WIDTH_REG_W'(1)) < w_eff;
    row_lo = (out_row_r != '0);
    row_hi = ({1'b0, out_row_r} + HEIGHT_REG_W'(1)) < h_eff;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        mask[dc * 3 + dr] = ((dc != 0) || col_lo) && ((dc != 2) || col_hi) &&
                            ((dr != 0) || row_lo) && ((dr != 2) || row_hi);
      end
    end
    count = CNT_W'($countones(mask));
  end

  // shared divisor reciprocal and end-of-frame flag
  always_ff @(posedge clk) begin
    if (lane_ctl.sum_en) begin
      recip_r <= recip_of(count);
      last_r  <= !row_hi && !col_hi;
    end
  end

  // one lane per colour channel, red first
  for (genvar ch = 0; ch < N_CH; ch++) begin : g_lane
    logic [WIN_N-1:0][CH_W-1:0] lane_px;

    always_comb begin
      for (int k = 0; k < WIN_N; k++) begin
        lane_px[k] = win_r[k][PIX_W - 1 - ch * CH_W -: CH_W];
      end
    end

    bb3_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .px    (lane_px),
      .mask  (mask),
      .count (count),
      .recip (recip_r),
      .avg   (avg[ch])
    );
  end

  // output position
  assign out_col_wrap = ({1'b0, out_col_r} + WIDTH_REG_W'(1)) >= w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (out_load) begin
      if (out_col_wrap) begin
        out_col_r <= '0;
        out_row_r <= out_row_r + OROW_W'(1);
      end else begin
        out_col_r <= out_col_r + COL_W'(1);
      end
    end
  end

  // merge lane results into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.red_out    <= avg[0];
      out_data_r.green_out  <= avg[1];
      out_data_r.blue_out   <= avg[2];
      out_data_r.last_pixel <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result is only loaded into a free or draining output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // input row never runs more than two rows past the frame (one-pixel-wide frames)
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, in_row_r} <= ({1'b0, h_eff} + ROW_W'(2))))
    else $error("input row beyond frame");

  // an output is only computed once at least a full row has entered
  a_emit_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (in_row_r != '0))
    else $error("output computed before its neighbours arrived");

  // a read cycle only follows a shift of a drain
  a_rd_after_sh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> ($past(state_r) == ST_SH && drain_r))
    else $error("line buffer read cycle out of sequence");

endmodule
